// ===== hw/rtl/bba_pkg.sv =====
`default_nettype none

package bba_pkg;

	localparam int REQ_W = 16;
	localparam int KW    = 5;

	localparam logic [1:0] OP_ALLOC  = 2'd0;
	localparam logic [1:0] OP_FREE   = 2'd1;
	localparam logic [1:0] OP_RESIZE = 2'd2;

	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_NOT_FOUND = 2'd1;
	localparam logic [1:0] STS_NO_MEM    = 2'd2;
	localparam logic [1:0] STS_BAD_SIZE  = 2'd3;

	typedef struct packed {
		logic [1:0]       op;
		logic [16:0]      addr;
		logic [REQ_W-1:0] request_bytes;
	} cmd_t;

	typedef struct packed {
		logic [15:0] result_addr;
		logic [1:0]  status;
		logic        moved;
		logic [4:0]  copy_order;
	} result_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_LOCATE,
		S_SHRINK,
		S_GROW_CHK,
		S_GROW_RM,
		S_REL,
		S_WALK,
		S_WALK_RD,
		S_WALK_RM,
		S_WALK_END,
		S_TAKE_FIND,
		S_TAKE_POP,
		S_TAKE_POPW,
		S_TAKE_SPLIT,
		S_MOVE
	} state_t;

	typedef enum logic [1:0] {
		CTX_REL,
		CTX_CHK,
		CTX_RMV
	} ctx_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bba_ram.sv =====
`default_nettype none

module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bba_heads.sv =====
`default_nettype none

// Free-list head registers, one per order, with a search for the
// smallest non-empty order at or above a given order.
module bba_heads #(
	parameter int NORD = 17,
	parameter int IW   = 14,
	parameter int OW   = 5
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [OW-1:0] rd_idx,
	output logic      [IW-1:0] rd_data,
	input  wire logic          wr_en,
	input  wire logic [OW-1:0] wr_idx,
	input  wire logic [IW-1:0] wr_data,
	input  wire logic [OW-1:0] min_ord,
	output logic               found,
	output logic      [OW-1:0] found_ord
);

	localparam logic [IW-1:0] NIL = IW'(1) << (IW - 1);

	logic [IW-1:0] heads_q [NORD];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int o = 0; o < NORD; o++) begin
				heads_q[o] <= (o == NORD - 1) ? '0 : NIL;
			end
		end else if (wr_en) begin
			heads_q[wr_idx] <= wr_data;
		end
	end

	assign rd_data = heads_q[rd_idx];

	// scan downward so the lowest qualifying order wins
	always_comb begin
		found     = 1'b0;
		found_ord = '0;
		for (int o = NORD - 1; o >= 0; o--) begin
			if (OW'(o) >= min_ord && !heads_q[o][IW-1]) begin
				found     = 1'b1;
				found_ord = OW'(o);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/buddy_block_allocator.sv =====
`default_nettype none

// Buddy allocator over a 2^HEAP_ORDER byte heap. After reset the block is busy while it sweeps
// the order memory to zero and the link memory to end-of-list. A command is taken when start
// is high and busy is low; its result appears on result for one cycle with done high and
// must be captured then. Command time is set by the free-list walks in the link memory: each
// visited list node passes through a walk state and a read state, each merge level adds a
// release, a walk and an unlink, and each split is a pass through the split state; a long walk
// grows linearly with the length of the list.
module buddy_block_allocator #(
	parameter int HEAP_ORDER = 16,
	parameter int MIN_ORDER  = 3
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire bba_pkg::cmd_t    cmd,
	output logic                  busy,
	output logic                  done,
	output bba_pkg::result_t      result
);

	import bba_pkg::*;

	localparam int BW   = HEAP_ORDER - MIN_ORDER;
	localparam int IW   = BW + 1;
	localparam int NBLK = 1 << BW;
	localparam int NORD = HEAP_ORDER + 1;
	localparam int OW   = $clog2(NORD);
	localparam logic [IW-1:0] NIL    = IW'(NBLK);
	localparam logic [OW-1:0] HEAP_O = OW'(HEAP_ORDER);
	localparam logic [OW-1:0] MIN_O  = OW'(MIN_ORDER);

	function automatic logic [BW-1:0] blk_bit(input logic [OW-1:0] o);
		return BW'(1) << (o - MIN_O);
	endfunction

	state_t state_q, state_d;
	ctx_t   ctx_q;

	logic [1:0]    op_q;
	logic          free_q;
	logic [16:0]   addr_q;
	logic [BW-1:0] idx_q, b_q, nb_q, tgt_q, clr_q;
	logic [OW-1:0] k_q, cs_q, t_q;
	logic [IW-1:0] p_q, prev_q;
	logic          found_q, rm_q;
	logic          done_q;
	result_t       result_q;

	// command decode
	logic [63:0]   a64;
	logic          range_bad, misal, req_zero, k_big, is_free;
	logic [BW-1:0] cmd_idx;
	logic [KW-1:0] req_k;

	always_comb begin
		a64       = 64'(cmd.addr);
		range_bad = (a64 >> HEAP_ORDER) != 64'd0;
		misal     = (a64 & ((64'd1 << MIN_ORDER) - 64'd1)) != 64'd0;
		cmd_idx   = a64[MIN_ORDER +: BW];
		req_zero  = cmd.request_bytes == '0;
		is_free   = cmd.op == OP_FREE || (cmd.op == OP_RESIZE && req_zero);
		req_k     = KW'(MIN_ORDER);
		for (int e = REQ_W; e >= MIN_ORDER; e--) begin
			if (((REQ_W + 1)'(1) << e) >= {1'b0, cmd.request_bytes}) begin
				req_k = KW'(e);
			end
		end
		k_big = int'(req_k) >= HEAP_ORDER;
	end

	// memories and head registers
	logic          bo_we, nl_we, hd_we;
	logic [BW-1:0] bo_waddr, nl_waddr, nl_raddr;
	logic [OW-1:0] bo_wdata, bo_rdata;
	logic [IW-1:0] nl_wdata, nl_rdata, hd_wdata, head_rd;
	logic [OW-1:0] hd_ridx, hd_widx, srch_ord;
	logic          srch_found;

	bba_ram #(.WIDTH(OW), .DEPTH(NBLK)) u_order_ram (
		.clk   (clk),
		.we    (bo_we),
		.waddr (bo_waddr),
		.wdata (bo_wdata),
		.raddr (cmd_idx),
		.rdata (bo_rdata)
	);

	bba_ram #(.WIDTH(IW), .DEPTH(NBLK)) u_link_ram (
		.clk   (clk),
		.we    (nl_we),
		.waddr (nl_waddr),
		.wdata (nl_wdata),
		.raddr (nl_raddr),
		.rdata (nl_rdata)
	);

	bba_heads #(.NORD(NORD), .IW(IW), .OW(OW)) u_heads (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_idx    (hd_ridx),
		.rd_data   (head_rd),
		.wr_en     (hd_we),
		.wr_idx    (hd_widx),
		.wr_data   (hd_wdata),
		.min_ord   (k_q),
		.found     (srch_found),
		.found_ord (srch_ord)
	);

	logic [63:0] b_byte, nb_byte;
	assign b_byte  = 64'(b_q) << MIN_ORDER;
	assign nb_byte = 64'(nb_q) << MIN_ORDER;

	logic          fin, fin_moved, push_en;
	logic [1:0]    fin_status;
	logic [15:0]   fin_addr;
	logic [4:0]    fin_corder;
	logic [BW-1:0] push_blk;

	always_comb begin
		state_d    = state_q;
		fin        = 1'b0;
		fin_status = STS_OK;
		fin_addr   = '0;
		fin_moved  = 1'b0;
		fin_corder = '0;
		bo_we      = 1'b0;
		bo_waddr   = idx_q;
		bo_wdata   = '0;
		nl_we      = 1'b0;
		nl_waddr   = prev_q[BW-1:0];
		nl_wdata   = nl_rdata;
		nl_raddr   = p_q[BW-1:0];
		hd_we      = 1'b0;
		hd_ridx    = t_q;
		hd_widx    = t_q;
		hd_wdata   = nl_rdata;
		push_en    = 1'b0;
		push_blk   = b_q;

		unique case (state_q)
			S_CLEAR: begin
				// the whole heap starts as one free block whose link ends the list
				bo_we    = 1'b1;
				bo_waddr = clr_q;
				nl_we    = 1'b1;
				nl_waddr = clr_q;
				nl_wdata = NIL;
				if (clr_q == '1) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					if (cmd.op == OP_ALLOC) begin
						if (req_zero || k_big) begin
							fin        = 1'b1;
							fin_status = STS_BAD_SIZE;
						end else begin
							state_d = S_TAKE_FIND;
						end
					end else if (is_free) begin
						if (range_bad || misal) begin
							fin        = 1'b1;
							fin_status = STS_NOT_FOUND;
						end else begin
							state_d = S_LOCATE;
						end
					end else if (cmd.op == OP_RESIZE) begin
						if (range_bad || (!k_big && misal)) begin
							fin        = 1'b1;
							fin_status = STS_NOT_FOUND;
						end else if (k_big) begin
							fin        = 1'b1;
							fin_status = STS_BAD_SIZE;
						end else begin
							state_d = S_LOCATE;
						end
					end else begin
						fin        = 1'b1;
						fin_status = STS_BAD_SIZE;
					end
				end
			end
			S_LOCATE: begin
				if (bo_rdata == '0) begin
					fin        = 1'b1;
					fin_status = STS_NOT_FOUND;
					state_d    = S_IDLE;
				end else if (free_q) begin
					bo_we   = 1'b1;
					state_d = S_REL;
				end else if (k_q < bo_rdata) begin
					state_d = S_SHRINK;
				end else if (k_q == bo_rdata) begin
					fin      = 1'b1;
					fin_addr = addr_q[15:0];
					state_d  = S_IDLE;
				end else begin
					state_d = S_GROW_CHK;
				end
			end
			S_SHRINK: begin
				if (t_q == cs_q) begin
					bo_we    = 1'b1;
					bo_wdata = k_q;
					fin      = 1'b1;
					fin_addr = addr_q[15:0];
					state_d  = S_IDLE;
				end else begin
					push_en  = 1'b1;
					push_blk = idx_q | blk_bit(t_q);
				end
			end
			S_GROW_CHK: begin
				if (t_q == k_q) begin
					state_d = S_GROW_RM;
				end else if ((idx_q & blk_bit(t_q)) != '0) begin
					state_d = S_TAKE_FIND;
				end else begin
					state_d = S_WALK;
				end
			end
			S_GROW_RM: begin
				if (t_q == k_q) begin
					bo_we    = 1'b1;
					bo_wdata = k_q;
					fin      = 1'b1;
					fin_addr = addr_q[15:0];
					state_d  = S_IDLE;
				end else begin
					state_d = S_WALK;
				end
			end
			S_REL: begin
				if (t_q == HEAP_O) begin
					push_en = 1'b1;
					fin     = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				if (p_q[BW]) begin
					state_d = S_WALK_END;
				end else if (p_q[BW-1:0] == tgt_q) begin
					nl_raddr = tgt_q;
					state_d  = rm_q ? S_WALK_RM : S_WALK_END;
				end else begin
					state_d = S_WALK_RD;
				end
			end
			S_WALK_RD: state_d = S_WALK;
			S_WALK_RM: begin
				// unlink the target: predecessor or head takes its successor
				if (prev_q[BW]) begin
					hd_we = 1'b1;
				end else begin
					nl_we = 1'b1;
				end
				state_d = S_WALK_END;
			end
			S_WALK_END: begin
				case (ctx_q)
					CTX_REL: begin
						if (found_q) begin
							state_d = S_REL;
						end else begin
							push_en = 1'b1;
							fin     = 1'b1;
							state_d = S_IDLE;
						end
					end
					CTX_CHK: state_d = found_q ? S_GROW_CHK : S_TAKE_FIND;
					default: state_d = S_GROW_RM;
				endcase
			end
			S_TAKE_FIND: begin
				if (!srch_found) begin
					fin        = 1'b1;
					fin_status = STS_NO_MEM;
					state_d    = S_IDLE;
				end else begin
					state_d = S_TAKE_POP;
				end
			end
			S_TAKE_POP: begin
				nl_raddr = head_rd[BW-1:0];
				state_d  = S_TAKE_POPW;
			end
			S_TAKE_POPW: begin
				hd_we   = 1'b1;
				state_d = S_TAKE_SPLIT;
			end
			S_TAKE_SPLIT: begin
				if (t_q == k_q) begin
					bo_we    = 1'b1;
					bo_waddr = b_q;
					bo_wdata = k_q;
					if (op_q == OP_ALLOC) begin
						fin      = 1'b1;
						fin_addr = b_byte[15:0];
						state_d  = S_IDLE;
					end else begin
						state_d = S_MOVE;
					end
				end else begin
					// keep the lower half, push the upper half one order down
					hd_ridx  = t_q - OW'(1);
					hd_widx  = t_q - OW'(1);
					push_en  = 1'b1;
					push_blk = b_q | blk_bit(t_q - OW'(1));
				end
			end
			S_MOVE: begin
				bo_we   = 1'b1;
				state_d = S_REL;
			end
			default: state_d = S_IDLE;
		endcase

		if (push_en) begin
			nl_we    = 1'b1;
			nl_waddr = push_blk;
			nl_wdata = head_rd;
			hd_we    = 1'b1;
			hd_wdata = {1'b0, push_blk};
		end

		// a release finishing a move reports the new block
		if (fin && fin_status == STS_OK && !free_q && op_q == OP_RESIZE &&
				(state_q == S_REL || state_q == S_WALK_END)) begin
			fin_addr   = nb_byte[15:0];
			fin_moved  = 1'b1;
			fin_corder = 5'(cs_q);
		end
	end

	assign busy = state_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (state_q == S_CLEAR) clr_q <= clr_q + BW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			result_q <= '{result_addr: fin_addr, status: fin_status, moved: fin_moved,
				copy_order: fin_corder};
		end
		case (state_q)
			S_IDLE: begin
				if (start) begin
					op_q   <= cmd.op;
					free_q <= is_free;
					addr_q <= cmd.addr;
					idx_q  <= cmd_idx;
					k_q    <= OW'(req_k);
				end
			end
			S_LOCATE: begin
				cs_q <= bo_rdata;
				b_q  <= idx_q;
				t_q  <= (!free_q && k_q < bo_rdata) ? k_q : bo_rdata;
			end
			S_SHRINK: t_q <= t_q + OW'(1);
			S_GROW_CHK: begin
				if (t_q == k_q) begin
					t_q <= cs_q;
				end else begin
					tgt_q  <= idx_q ^ blk_bit(t_q);
					p_q    <= head_rd;
					prev_q <= NIL;
					rm_q   <= 1'b0;
					ctx_q  <= CTX_CHK;
				end
			end
			S_GROW_RM: begin
				tgt_q  <= idx_q ^ blk_bit(t_q);
				p_q    <= head_rd;
				prev_q <= NIL;
				rm_q   <= 1'b1;
				ctx_q  <= CTX_RMV;
			end
			S_REL: begin
				tgt_q  <= b_q ^ blk_bit(t_q);
				p_q    <= head_rd;
				prev_q <= NIL;
				rm_q   <= 1'b1;
				ctx_q  <= CTX_REL;
			end
			S_WALK: begin
				if (p_q[BW]) begin
					found_q <= 1'b0;
				end else if (p_q[BW-1:0] == tgt_q) begin
					found_q <= 1'b1;
				end else begin
					prev_q <= p_q;
				end
			end
			S_WALK_RD: p_q <= nl_rdata;
			S_WALK_END: begin
				if (ctx_q == CTX_REL && found_q) begin
					b_q <= b_q & ~blk_bit(t_q);
					t_q <= t_q + OW'(1);
				end else if (ctx_q != CTX_REL && (found_q || ctx_q == CTX_RMV)) begin
					t_q <= t_q + OW'(1);
				end
			end
			S_TAKE_FIND: t_q <= srch_ord;
			S_TAKE_POP:  b_q <= head_rd[BW-1:0];
			S_TAKE_SPLIT: begin
				if (t_q == k_q) begin
					nb_q <= b_q;
				end else begin
					t_q <= t_q - OW'(1);
				end
			end
			S_MOVE: begin
				b_q <= idx_q;
				t_q <= cs_q;
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire
